>>> rtl/wsfd_pkg.sv
package wsfd_pkg;

  // parser phases
  typedef enum logic [2:0] {
    PH_B0    = 3'd0,
    PH_B1    = 3'd1,
    PH_LEN16 = 3'd2,
    PH_LEN64 = 3'd3,
    PH_KEY   = 3'd4,
    PH_DATA  = 3'd5
  } phase_e;

  // default depth of the queue between parser and output stage
  localparam int unsigned WSFD_QUEUE_DEPTH = 4;

  // 7-bit length codes that announce an extended length
  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;

  // byte counts of the header fields, modulo 8
  localparam logic [2:0] LEN16_BYTES = 3'd2;
  localparam logic [2:0] LEN64_BYTES = 3'd0;
  localparam logic [2:0] KEY_BYTES   = 3'd4;

  // one queued result: raw byte and the key byte to apply to it
  typedef struct packed {
    logic [7:0] raw;
    logic [7:0] key;
    logic       data_valid;
    logic [3:0] opcode;
    logic       fin;
    logic       masked;
    logic       last;
  } entry_t;

endpackage

>>> rtl/wsfd_front.sv
module wsfd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [7:0]          in_byte_i,
  output logic                in_ready_o,
  input  logic                q_ready_i,
  output logic                q_push_o,
  output wsfd_pkg::entry_t    q_entry_o
);
  import wsfd_pkg::*;

  phase_e          phase_q, phase_d;
  logic [2:0]      cnt_q, cnt_d;
  logic [63:0]     rem_q, rem_d;
  logic [3:0][7:0] key_q, key_d;
  logic [1:0]      kpos_q, kpos_d;
  logic            masked_q, masked_d;
  logic            fin_q, fin_d;
  logic [3:0]      op_q, op_d;

  logic            accept;
  logic            emit;
  logic            len_done;
  logic            hdr_done;
  logic [63:0]     rem_shift;
  logic [63:0]     rem_dec;
  logic [2:0]      cnt_inc;
  logic [6:0]      len7;
  logic [7:0]      ent_raw;
  logic [7:0]      ent_key;
  logic            ent_valid;
  logic            ent_last;

  assign in_ready_o = q_ready_i;
  assign accept     = in_valid_i && q_ready_i;

  // header parsing and payload classification
  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    key_d     = key_q;
    kpos_d    = kpos_q;
    masked_d  = masked_q;
    fin_d     = fin_q;
    op_d      = op_q;
    emit      = 1'b0;
    len_done  = 1'b0;
    hdr_done  = 1'b0;
    ent_raw   = 8'd0;
    ent_key   = 8'd0;
    ent_valid = 1'b0;
    ent_last  = 1'b0;
    rem_shift = {rem_q[55:0], in_byte_i};
    rem_dec   = rem_q - 64'd1;
    cnt_inc   = cnt_q + 3'd1;
    len7      = in_byte_i[6:0];
    if (accept) begin
      case (phase_q)
        PH_B1: begin
          masked_d = in_byte_i[7];
          cnt_d    = 3'd0;
          rem_d    = 64'd0;
          if (len7 == LEN_CODE_16) begin
            phase_d = PH_LEN16;
          end else if (len7 == LEN_CODE_64) begin
            phase_d = PH_LEN64;
          end else begin
            rem_d    = {57'd0, len7};
            len_done = 1'b1;
          end
        end
        PH_LEN16, PH_LEN64: begin
          rem_d = rem_shift;
          cnt_d = cnt_inc;
          if (cnt_inc == ((phase_q == PH_LEN16) ? LEN16_BYTES : LEN64_BYTES)) begin
            len_done = 1'b1;
          end
        end
        PH_KEY: begin
          key_d[cnt_q[1:0]] = in_byte_i;
          cnt_d             = cnt_inc;
          if (cnt_inc == KEY_BYTES) begin
            cnt_d    = 3'd0;
            hdr_done = 1'b1;
          end
        end
        PH_DATA: begin
          ent_raw   = in_byte_i;
          ent_key   = masked_q ? key_q[kpos_q] : 8'd0;
          ent_valid = 1'b1;
          ent_last  = (rem_dec == 64'd0);
          kpos_d    = kpos_q + 2'd1;
          rem_d     = rem_dec;
          emit      = 1'b1;
          if (ent_last) begin
            phase_d = PH_B0;
          end
        end
        default: begin
          fin_d    = in_byte_i[7];
          op_d     = in_byte_i[3:0];
          masked_d = 1'b0;
          rem_d    = 64'd0;
          cnt_d    = 3'd0;
          kpos_d   = 2'd0;
          phase_d  = PH_B1;
        end
      endcase

      // length known: go fetch the key or finish the header
      if (len_done) begin
        cnt_d = 3'd0;
        if (masked_d) begin
          phase_d = PH_KEY;
        end else begin
          hdr_done = 1'b1;
        end
      end

      // header complete: payload or empty-frame marker
      if (hdr_done) begin
        kpos_d = 2'd0;
        if (rem_d == 64'd0) begin
          phase_d  = PH_B0;
          emit     = 1'b1;
          ent_last = 1'b1;
        end else begin
          phase_d = PH_DATA;
        end
      end
    end
  end

  assign q_push_o             = emit;
  assign q_entry_o.raw        = ent_raw;
  assign q_entry_o.key        = ent_key;
  assign q_entry_o.data_valid = ent_valid;
  assign q_entry_o.opcode     = op_d;
  assign q_entry_o.fin        = fin_d;
  assign q_entry_o.masked     = masked_d;
  assign q_entry_o.last       = ent_last;

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_B0;
      cnt_q    <= 3'd0;
      rem_q    <= 64'd0;
      key_q    <= '0;
      kpos_q   <= 2'd0;
      masked_q <= 1'b0;
      fin_q    <= 1'b0;
      op_q     <= 4'd0;
    end else begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      rem_q    <= rem_d;
      key_q    <= key_d;
      kpos_q   <= kpos_d;
      masked_q <= masked_d;
      fin_q    <= fin_d;
      op_q     <= op_d;
    end
  end

  // payload phase always has bytes left to count
  a_data_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> rem_q != 64'd0)
    else $error("payload phase with zero remaining length");

  // an empty-frame marker always closes its frame
  a_marker_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push_o && !q_entry_o.data_valid |-> q_entry_o.last && q_entry_o.raw == 8'd0)
    else $error("marker without frame end");

endmodule

>>> rtl/wsfd_queue.sv
module wsfd_queue #(
  parameter int unsigned Depth = wsfd_pkg::WSFD_QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  wsfd_pkg::entry_t push_entry_i,
  output logic             ready_o,
  input  logic             pop_i,
  output logic             valid_o,
  output wsfd_pkg::entry_t pop_entry_o
);
  import wsfd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  assign ready_o     = (cnt_q != FullCnt);
  assign valid_o     = (cnt_q != '0);
  assign do_push     = push_i && ready_o;
  assign do_pop      = pop_i && valid_o;
  assign pop_entry_o = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt)
    else $error("queue fill count beyond depth");

  a_cnt_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_push && !do_pop |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue count did not follow a lone push");

endmodule

>>> rtl/wsfd_back.sv
module wsfd_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  wsfd_pkg::entry_t q_entry_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       out_data_o,
  output logic [6:0]       out_user_o,
  output logic             out_last_o
);
  import wsfd_pkg::*;

  logic       valid_q, valid_d;
  logic [7:0] data_q;
  logic [6:0] user_q;
  logic       last_q;
  logic       load;

  // refill the output register when it is empty or being drained
  assign load    = q_valid_i && (!valid_q || out_ready_i);
  assign q_pop_o = load;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // unmask and register the result
  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= q_entry_i.raw ^ q_entry_i.key;
      user_q <= {q_entry_i.masked, q_entry_i.fin, q_entry_i.opcode, q_entry_i.data_valid};
      last_q <= q_entry_i.last;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;
  assign out_user_o  = user_q;
  assign out_last_o  = last_q;

endmodule

>>> rtl/websocket_frame_decoder.sv
// channel   | dir | tdata                 | tuser                                | tlast
// s_axis    | in  | [7:0] rx_byte         | -                                    | -
// m_axis    | out | [7:0] data_byte       | [0] valid [4:1] opcode [5] fin [6] mask | frame_end
//
// one byte per cycle sustained while the queue has room; a payload result waits in the queue
// and then in the output register; only an empty frame's last header byte gives a transfer
// (a marker); the 64-bit length decrement and zero compare in the parser set the cycle time
// reset clears parser phase, queue and output valid; no clearing pass
// s_axis_tready falls only when the queue is full, so output stalls reach the
// input after the queue and the output register have filled
module websocket_frame_decoder #(
  parameter int unsigned QueueDepth = wsfd_pkg::WSFD_QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] data_byte
  output logic [6:0] m_axis_tuser,   // [0] data_valid, [4:1] frame_opcode,
                                     // [5] final_fragment, [6] was_masked
  output logic       m_axis_tlast    // frame_end
);
  import wsfd_pkg::*;

  logic   push;
  logic   q_ready;
  logic   q_valid;
  logic   pop;
  entry_t push_entry;
  entry_t pop_entry;

  // header parser and payload classifier
  wsfd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_byte_i  (s_axis_tdata),
    .in_ready_o (s_axis_tready),
    .q_ready_i  (q_ready),
    .q_push_o   (push),
    .q_entry_o  (push_entry)
  );

  // decoupling queue
  wsfd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .ready_o      (q_ready),
    .pop_i        (pop),
    .valid_o      (q_valid),
    .pop_entry_o  (pop_entry)
  );

  // unmasking and output register
  wsfd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_entry_i   (pop_entry),
    .q_pop_o     (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule
